// ----- src/ddcs_pkg.sv -----
// Shared types, codes and helpers for the DSI DCS command processor.
package ddcs_pkg;

    localparam int ChannelWidth = 2;
    localparam int HeaderWidth  = 8;
    localparam int PayloadWidth = 32;
    localparam int CountWidth   = 16;
    localparam int InDataWidth  = 56;
    localparam int OutDataWidth = 16;

    localparam logic [5:0] ID_MASK = 6'h3f;

    localparam logic [5:0] DT_DCS_SHORT_WR0 = 6'h05;
    localparam logic [5:0] DT_DCS_READ      = 6'h06;
    localparam logic [5:0] DT_NULL          = 6'h09;
    localparam logic [5:0] DT_DCS_SHORT_WR1 = 6'h15;
    localparam logic [5:0] DT_SET_MAX_RET   = 6'h37;
    localparam logic [5:0] DT_DCS_LONG_WR   = 6'h39;

    localparam logic [7:0] DCS_SLEEP_IN     = 8'h10;
    localparam logic [7:0] DCS_SLEEP_OUT    = 8'h11;
    localparam logic [7:0] DCS_DISPLAY_OFF  = 8'h28;
    localparam logic [7:0] DCS_DISPLAY_ON   = 8'h29;
    localparam logic [7:0] DCS_SET_COLUMN   = 8'h2a;
    localparam logic [7:0] DCS_SET_PAGE     = 8'h2b;
    localparam logic [7:0] DCS_TEAR_OFF     = 8'h34;
    localparam logic [7:0] DCS_TEAR_ON      = 8'h35;
    localparam logic [7:0] DCS_ADDR_MODE    = 8'h36;
    localparam logic [7:0] DCS_PIXEL_FORMAT = 8'h3a;
    localparam logic [7:0] DCS_GET_POWER    = 8'h0a;
    localparam logic [7:0] DCS_GET_ADDR     = 8'h0b;
    localparam logic [7:0] DCS_GET_DIAG     = 8'h0f;

    localparam logic [7:0] POWER_RESET   = 8'h08;
    localparam logic [7:0] POWER_SLEEP   = 8'h10;
    localparam logic [7:0] POWER_DISPLAY = 8'h04;
    localparam logic [7:0] DIAG_TOGGLE   = 8'he0;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_WRONG_CHANNEL = 3'd1,
        ST_BAD_TYPE      = 3'd2,
        ST_UNKNOWN_CMD   = 3'd3,
        ST_BAD_FORMAT    = 3'd4,
        ST_READ_PENDING  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        TEAR_OFF    = 2'd0,
        TEAR_VSYNC  = 2'd1,
        TEAR_HVSYNC = 2'd2
    } tear_t;

    typedef struct packed {
        logic                    cmd;
        logic [HeaderWidth-1:0]  header;
        logic [PayloadWidth-1:0] payload;
        logic [CountWidth-1:0]   byte_count;
    } packet_t;

    typedef struct packed {
        logic       response_valid;
        logic [7:0] read_byte;
        logic       power_changed;
        logic       tear_changed;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] bytes;
    } fmt_t;

    function automatic fmt_t fmt_bytes(input logic [2:0] f);
        fmt_t r;
        r.ok = 1'b1;
        unique case (f)
            3'd0:    r.bytes = 3'd0;
            3'd2:    r.bytes = 3'd1;
            3'd5:    r.bytes = 3'd2;
            3'd7:    r.bytes = 3'd4;
            default: begin
                r.ok    = 1'b0;
                r.bytes = 3'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- src/dsi_dcs_command_processor.sv -----
// DSI DCS command processor: one packet in, one status/response transaction out.
// Takes one short or long DSI packet per cycle and returns exactly one result
// transaction per packet. Throughput is one packet per clock while m_axis_tready
// stays high. A packet accepted from s_axis is held in the input register, decoded
// from it and moved into the result register once that register is free, and
// m_axis_tvalid is driven by the result register. A low m_axis_tready holds the result
// register, and once the input register is also full s_axis_tready drops. The
// DCS state updates as a packet leaves the input register, so back-to-back
// packets see each other's effects in order. Any nonzero status leaves the
// state untouched. own_channel is written through cfg_wr_en / cfg_wr_data and
// should be changed only while the block is idle.
module dsi_dcs_command_processor
    import ddcs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [ChannelWidth-1:0] cfg_wr_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [7:0] header, [39:8] payload, [55:40] byte_count
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [7:0] read_byte, [8] power_changed, [9] tear_changed, [12:10] status, [15:13] zero
    output logic [OutDataWidth-1:0] m_axis_tdata,
    // [0] response_valid
    output logic                    m_axis_tuser
);

    logic    in_valid_reg;
    packet_t in_pkt_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    logic    out_free;
    logic    advance;

    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign advance       = in_valid_reg & out_free;
    assign s_axis_tready = ~in_valid_reg | out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_pkt_reg.cmd        <= s_axis_tuser;
            in_pkt_reg.header     <= s_axis_tdata[7:0];
            in_pkt_reg.payload    <= s_axis_tdata[39:8];
            in_pkt_reg.byte_count <= s_axis_tdata[55:40];
        end
    end

    ddcs_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pkt         (in_pkt_reg),
        .commit      (advance),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.response_valid;
    assign m_axis_tdata  = {3'd0, out_res_reg.status, out_res_reg.tear_changed,
                            out_res_reg.power_changed, out_res_reg.read_byte};

endmodule

// ----- src/ddcs_engine.sv -----
// Packet decode, DCS interpreter state and result generation.
module ddcs_engine
    import ddcs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [ChannelWidth-1:0] cfg_wr_data,
    input  packet_t                 pkt,
    input  logic                    commit,
    output result_t                 res
);

    logic [ChannelWidth-1:0] own_channel_reg;
    logic        await_reg,      await_next;
    logic [7:0]  cur_cmd_reg,    cur_cmd_next;
    logic [7:0]  power_reg,      power_next;
    logic [7:0]  addr_mode_reg,  addr_mode_next;
    logic [7:0]  diag_reg,       diag_next;
    logic [2:0]  dpi_reg,        dpi_next;
    logic [2:0]  dbi_reg,        dbi_next;
    logic [15:0] col_start_reg,  col_start_next;
    logic [15:0] col_end_reg,    col_end_next;
    logic [15:0] col_cur_reg,    col_cur_next;
    logic [15:0] page_start_reg, page_start_next;
    logic [15:0] page_end_reg,   page_end_next;
    logic [15:0] page_cur_reg,   page_cur_next;
    tear_t       tear_reg,       tear_next;
    logic [15:0] max_ret_reg,    max_ret_next;

    logic [5:0]  id;
    logic [31:0] long_mask;
    logic [31:0] wdata;
    logic        is_write;
    logic        first;
    logic [7:0]  wc;
    logic [23:0] wd;
    fmt_t        fmt_dpi;
    fmt_t        fmt_dbi;
    status_t     st;
    logic        pwr_chg;
    logic        tear_chg;
    logic        rd_valid;
    logic [7:0]  rd_byte;

    assign id      = pkt.header[5:0] & ID_MASK;
    assign first   = ~await_reg;
    assign wc      = first ? wdata[7:0] : cur_cmd_reg;
    assign wd      = first ? wdata[31:8] : wdata[23:0];
    assign fmt_dpi = fmt_bytes(wd[6:4]);
    assign fmt_dbi = fmt_bytes(wd[2:0]);

    always_comb begin
        priority if (pkt.byte_count >= 16'd4) begin
            long_mask = 32'hffff_ffff;
        end else if (pkt.byte_count == 16'd3) begin
            long_mask = 32'h00ff_ffff;
        end else if (pkt.byte_count == 16'd2) begin
            long_mask = 32'h0000_ffff;
        end else if (pkt.byte_count == 16'd1) begin
            long_mask = 32'h0000_00ff;
        end else begin
            long_mask = 32'h0000_0000;
        end
    end

    always_comb begin
        await_next      = await_reg;
        cur_cmd_next    = cur_cmd_reg;
        power_next      = power_reg;
        addr_mode_next  = addr_mode_reg;
        diag_next       = diag_reg;
        dpi_next        = dpi_reg;
        dbi_next        = dbi_reg;
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        col_cur_next    = col_cur_reg;
        page_start_next = page_start_reg;
        page_end_next   = page_end_reg;
        page_cur_next   = page_cur_reg;
        tear_next       = tear_reg;
        max_ret_next    = max_ret_reg;
        st              = ST_OK;
        is_write        = 1'b0;
        wdata           = 32'd0;
        pwr_chg         = 1'b0;
        tear_chg        = 1'b0;
        rd_valid        = 1'b0;
        rd_byte         = 8'd0;

        if (pkt.header[7:6] != own_channel_reg) begin
            st = ST_WRONG_CHANNEL;
        end else if (!pkt.cmd) begin
            unique case (id)
                DT_DCS_SHORT_WR0: begin
                    is_write = 1'b1;
                    wdata    = {24'd0, pkt.payload[7:0]};
                end
                DT_DCS_SHORT_WR1: begin
                    is_write = 1'b1;
                    wdata    = {16'd0, pkt.payload[15:0]};
                end
                DT_DCS_READ: begin
                    if (await_reg) begin
                        st = ST_READ_PENDING;
                    end else begin
                        unique case (pkt.payload[7:0])
                            DCS_GET_POWER: rd_byte = power_reg;
                            DCS_GET_ADDR:  rd_byte = addr_mode_reg;
                            DCS_GET_DIAG:  rd_byte = diag_reg;
                            default:       st      = ST_UNKNOWN_CMD;
                        endcase
                        rd_valid     = 1'b1;
                        cur_cmd_next = pkt.payload[7:0];
                    end
                end
                DT_SET_MAX_RET: max_ret_next = pkt.payload[15:0];
                default:        st = ST_BAD_TYPE;
            endcase
        end else begin
            unique case (id)
                DT_NULL: ;
                DT_DCS_LONG_WR: begin
                    is_write = 1'b1;
                    wdata    = pkt.payload & long_mask;
                end
                default: st = ST_BAD_TYPE;
            endcase
        end

        if (is_write) begin
            cur_cmd_next = wc;
            unique case (wc)
                DCS_SLEEP_IN, DCS_SLEEP_OUT, DCS_DISPLAY_OFF, DCS_DISPLAY_ON: begin
                    unique case (wc)
                        DCS_SLEEP_IN:    power_next = power_reg & ~POWER_SLEEP;
                        DCS_SLEEP_OUT:   power_next = power_reg | POWER_SLEEP;
                        DCS_DISPLAY_OFF: power_next = power_reg & ~POWER_DISPLAY;
                        default:         power_next = power_reg | POWER_DISPLAY;
                    endcase
                    if (wc == DCS_SLEEP_OUT) begin
                        diag_next = diag_reg ^ DIAG_TOGGLE;
                    end
                    pwr_chg = (power_next != power_reg);
                end
                DCS_SET_COLUMN: begin
                    if (first) begin
                        col_start_next = {wd[7:0], wd[15:8]};
                        col_end_next   = {8'd0, wd[23:16]};
                        await_next     = 1'b1;
                    end else begin
                        col_end_next   = {col_end_reg[7:0], wd[7:0]};
                        await_next     = 1'b0;
                    end
                    col_cur_next = col_start_next;
                end
                DCS_SET_PAGE: begin
                    if (first) begin
                        page_start_next = {wd[7:0], wd[15:8]};
                        page_end_next   = {8'd0, wd[23:16]};
                        await_next      = 1'b1;
                    end else begin
                        page_end_next   = {page_end_reg[7:0], wd[7:0]};
                        await_next      = 1'b0;
                    end
                    page_cur_next = page_start_next;
                end
                DCS_TEAR_OFF, DCS_TEAR_ON: begin
                    if (wc == DCS_TEAR_OFF) begin
                        tear_next = TEAR_OFF;
                    end else if (wd[0]) begin
                        tear_next = TEAR_HVSYNC;
                    end else begin
                        tear_next = TEAR_VSYNC;
                    end
                    tear_chg = (tear_next != tear_reg);
                end
                DCS_ADDR_MODE: addr_mode_next = wd[7:0];
                DCS_PIXEL_FORMAT: begin
                    if (!fmt_dpi.ok || !fmt_dbi.ok) begin
                        st = ST_BAD_FORMAT;
                    end
                    dpi_next = fmt_dpi.bytes;
                    dbi_next = fmt_dbi.bytes;
                end
                default: st = ST_UNKNOWN_CMD;
            endcase
        end

        res.status         = st;
        res.response_valid = (st == ST_OK) & rd_valid;
        res.read_byte      = (st == ST_OK) ? rd_byte : 8'd0;
        res.power_changed  = (st == ST_OK) & pwr_chg;
        res.tear_changed   = (st == ST_OK) & tear_chg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_channel_reg <= '0;
        end else if (cfg_wr_en) begin
            own_channel_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            await_reg      <= 1'b0;
            cur_cmd_reg    <= 8'd0;
            power_reg      <= POWER_RESET;
            addr_mode_reg  <= 8'd0;
            diag_reg       <= 8'd0;
            dpi_reg        <= 3'd0;
            dbi_reg        <= 3'd0;
            col_start_reg  <= 16'd0;
            col_end_reg    <= 16'd0;
            col_cur_reg    <= 16'd0;
            page_start_reg <= 16'd0;
            page_end_reg   <= 16'd0;
            page_cur_reg   <= 16'd0;
            tear_reg       <= TEAR_OFF;
            max_ret_reg    <= 16'd0;
        end else if (commit && st == ST_OK) begin
            await_reg      <= await_next;
            cur_cmd_reg    <= cur_cmd_next;
            power_reg      <= power_next;
            addr_mode_reg  <= addr_mode_next;
            diag_reg       <= diag_next;
            dpi_reg        <= dpi_next;
            dbi_reg        <= dbi_next;
            col_start_reg  <= col_start_next;
            col_end_reg    <= col_end_next;
            col_cur_reg    <= col_cur_next;
            page_start_reg <= page_start_next;
            page_end_reg   <= page_end_next;
            page_cur_reg   <= page_cur_next;
            tear_reg       <= tear_next;
            max_ret_reg    <= max_ret_next;
        end
    end

endmodule

// ----- tb/dsi_dcs_command_processor_tb.sv -----
// Self-checking testbench for the DSI DCS command processor stream interface.
`timescale 1ns / 1ps

module dsi_dcs_command_processor_tb;
    import ddcs_pkg::*;

    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic        param_phase;
        logic [7:0]  cur_cmd;
        logic [7:0]  pwr;
        logic [7:0]  addr;
        logic [7:0]  diag;
        logic [2:0]  dpi;
        logic [2:0]  dbi;
        logic [15:0] col_s;
        logic [15:0] col_e;
        logic [15:0] col_c;
        logic [15:0] pg_s;
        logic [15:0] pg_e;
        logic [15:0] pg_c;
        logic [1:0]  tear;
        logic [15:0] max_ret;
    } dcs_state_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [ChannelWidth-1:0] cfg_wr_data   = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OutDataWidth-1:0] m_axis_tdata;
    logic                    m_axis_tuser;

    dsi_dcs_command_processor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    packet_t    packet_q[$];
    result_t    pending_results[$];
    dcs_state_t dcs;
    dcs_state_t dcs_nxt;
    logic [1:0] own_ch = 2'd0;
    int         n_items = 0;
    int         errors = 0;
    int         cycles = 0;

    logic [7:0] wr_cmds[11] = '{DCS_SLEEP_IN, DCS_SLEEP_OUT, DCS_DISPLAY_OFF, DCS_DISPLAY_ON,
                                DCS_SET_COLUMN, DCS_SET_PAGE, DCS_TEAR_OFF, DCS_TEAR_ON,
                                DCS_ADDR_MODE, DCS_PIXEL_FORMAT, DCS_PIXEL_FORMAT};
    logic [7:0] rd_cmds[3] = '{DCS_GET_POWER, DCS_GET_ADDR, DCS_GET_DIAG};
    logic [2:0] good_fmts[4] = '{3'd0, 3'd2, 3'd5, 3'd7};

    // {valid, bytes per pixel}
    function automatic logic [3:0] pixel_bytes(input logic [2:0] f);
        case (f)
            3'd0:    return 4'b1_000;
            3'd2:    return 4'b1_001;
            3'd5:    return 4'b1_010;
            3'd7:    return 4'b1_100;
            default: return 4'b0_000;
        endcase
    endfunction

    function automatic status_t dcs_write(input logic [31:0] d_in, output logic pc,
                                          output logic tc);
        logic [31:0] d;
        logic [7:0]  c;
        logic [7:0]  np;
        logic [1:0]  nt;
        logic [3:0]  fa;
        logic [3:0]  fb;
        logic        first;
        pc = 1'b0;
        tc = 1'b0;
        d = d_in;
        first = !dcs_nxt.param_phase;
        if (first) begin
            c = d[7:0];
            d = d >> 8;
        end else begin
            c = dcs_nxt.cur_cmd;
        end
        case (c)
            DCS_SLEEP_IN, DCS_SLEEP_OUT, DCS_DISPLAY_OFF, DCS_DISPLAY_ON: begin
                np = dcs_nxt.pwr;
                case (c)
                    DCS_SLEEP_IN:    np = np & ~POWER_SLEEP;
                    DCS_SLEEP_OUT:   np = np | POWER_SLEEP;
                    DCS_DISPLAY_OFF: np = np & ~POWER_DISPLAY;
                    default:         np = np | POWER_DISPLAY;
                endcase
                if (c == DCS_SLEEP_OUT) dcs_nxt.diag = dcs_nxt.diag ^ DIAG_TOGGLE;
                pc = (np != dcs_nxt.pwr);
                dcs_nxt.pwr = np;
            end
            DCS_SET_COLUMN: begin
                if (first) begin
                    dcs_nxt.col_s = {d[7:0], d[15:8]};
                    dcs_nxt.col_e = {8'h00, d[23:16]};
                    dcs_nxt.param_phase = 1'b1;
                end else begin
                    dcs_nxt.col_e = {dcs_nxt.col_e[7:0], d[7:0]};
                    dcs_nxt.param_phase = 1'b0;
                end
                dcs_nxt.col_c = dcs_nxt.col_s;
            end
            DCS_SET_PAGE: begin
                if (first) begin
                    dcs_nxt.pg_s = {d[7:0], d[15:8]};
                    dcs_nxt.pg_e = {8'h00, d[23:16]};
                    dcs_nxt.param_phase = 1'b1;
                end else begin
                    dcs_nxt.pg_e = {dcs_nxt.pg_e[7:0], d[7:0]};
                    dcs_nxt.param_phase = 1'b0;
                end
                dcs_nxt.pg_c = dcs_nxt.pg_s;
            end
            DCS_TEAR_OFF, DCS_TEAR_ON: begin
                nt = (c == DCS_TEAR_OFF) ? TEAR_OFF : (d[0] ? TEAR_HVSYNC : TEAR_VSYNC);
                tc = (nt != dcs_nxt.tear);
                dcs_nxt.tear = nt;
            end
            DCS_ADDR_MODE: dcs_nxt.addr = d[7:0];
            DCS_PIXEL_FORMAT: begin
                fa = pixel_bytes(d[6:4]);
                fb = pixel_bytes(d[2:0]);
                if (!fa[3] || !fb[3]) return ST_BAD_FORMAT;
                dcs_nxt.dpi = fa[2:0];
                dcs_nxt.dbi = fb[2:0];
            end
            default: return ST_UNKNOWN_CMD;
        endcase
        dcs_nxt.cur_cmd = c;
        return ST_OK;
    endfunction

    // Expected result of one packet; state moves on only when status is ok.
    function automatic result_t dcs_decode(input packet_t p);
        result_t     r;
        status_t     st;
        logic        rv;
        logic        pc;
        logic        tc;
        logic [7:0]  rb;
        logic [31:0] mask;
        dcs_nxt = dcs;
        rv = 1'b0;
        rb = 8'h00;
        pc = 1'b0;
        tc = 1'b0;
        st = ST_OK;
        if (p.header[7:6] != own_ch) begin
            st = ST_WRONG_CHANNEL;
        end else if (!p.cmd) begin
            case (p.header[5:0])
                DT_DCS_SHORT_WR0: st = dcs_write({24'h0, p.payload[7:0]}, pc, tc);
                DT_DCS_SHORT_WR1: st = dcs_write({16'h0, p.payload[15:0]}, pc, tc);
                DT_SET_MAX_RET:   dcs_nxt.max_ret = p.payload[15:0];
                DT_DCS_READ: begin
                    if (dcs.param_phase) begin
                        st = ST_READ_PENDING;
                    end else begin
                        case (p.payload[7:0])
                            DCS_GET_POWER: rb = dcs.pwr;
                            DCS_GET_ADDR:  rb = dcs.addr;
                            DCS_GET_DIAG:  rb = dcs.diag;
                            default:       st = ST_UNKNOWN_CMD;
                        endcase
                        rv = 1'b1;
                        dcs_nxt.cur_cmd = p.payload[7:0];
                    end
                end
                default: st = ST_BAD_TYPE;
            endcase
        end else begin
            case (p.header[5:0])
                DT_NULL: ;
                DT_DCS_LONG_WR: begin
                    if (p.byte_count >= 16'd4) mask = '1;
                    else mask = (32'h1 << (8 * p.byte_count[2:0])) - 32'h1;
                    st = dcs_write(p.payload & mask, pc, tc);
                end
                default: st = ST_BAD_TYPE;
            endcase
        end
        if (st != ST_OK) begin
            rv = 1'b0;
            rb = 8'h00;
            pc = 1'b0;
            tc = 1'b0;
        end else begin
            dcs = dcs_nxt;
        end
        r.response_valid = rv;
        r.read_byte = rb;
        r.power_changed = pc;
        r.tear_changed = tc;
        r.status = st;
        return r;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    packet_t drv_pkt;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) pending_results.push_back(dcs_decode(drv_pkt));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (packet_q.size() > 0) begin
                    drv_pkt = packet_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {drv_pkt.byte_count, drv_pkt.payload, drv_pkt.header};
                    s_axis_tuser <= drv_pkt.cmd;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Monitor with its own stall pattern on tready.
    int      rdy_tick = 0;
    int      rdy_mode = 0;
    result_t exp_r;
    result_t act_r;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            act_r.response_valid = m_axis_tuser;
            act_r.read_byte = m_axis_tdata[7:0];
            act_r.power_changed = m_axis_tdata[8];
            act_r.tear_changed = m_axis_tdata[9];
            act_r.status = status_t'(m_axis_tdata[12:10]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h/%h",
                         $realtime, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("response_valid", 8'(exp_r.response_valid),
                            8'(act_r.response_valid));
                check_field("read_byte", exp_r.read_byte, act_r.read_byte);
                check_field("power_changed", 8'(exp_r.power_changed),
                            8'(act_r.power_changed));
                check_field("tear_changed", 8'(exp_r.tear_changed), 8'(act_r.tear_changed));
                check_field("status", 8'(exp_r.status), 8'(act_r.status));
                check_field("tdata pad", 8'h00, 8'(m_axis_tdata[15:13]));
            end
        end
        rdy_tick++;
        if (rdy_tick % 64 == 0) rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rdy_tick % 5) < 3;
        endcase
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_pkt(input logic cmd, input logic [1:0] vc, input logic [5:0] dt,
                           input logic [31:0] pay, input logic [15:0] cnt);
        packet_t p;
        p.cmd = cmd;
        p.header = {vc, dt};
        p.payload = pay;
        p.byte_count = cnt;
        packet_q.push_back(p);
        n_items++;
    endtask

    // One DCS write in a random encoding; junk fills the unused payload bits.
    task automatic add_write(input logic [1:0] vc, input logic [7:0] c, input logic [23:0] prm);
        logic [31:0] junk;
        logic [15:0] cnt;
        junk = $urandom();
        case ($urandom_range(0, 2))
            0: add_pkt(1'b0, vc, DT_DCS_SHORT_WR0, {junk[31:8], c}, junk[15:0]);
            1: add_pkt(1'b0, vc, DT_DCS_SHORT_WR1, {junk[31:16], prm[7:0], c}, junk[15:0]);
            default: begin
                cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
                add_pkt(1'b1, vc, DT_DCS_LONG_WR, {prm, c}, cnt);
            end
        endcase
    endtask

    task automatic add_random(input logic [1:0] vc);
        int          sel;
        logic [7:0]  c;
        logic [31:0] r;
        sel = $urandom_range(0, 99);
        r = $urandom();
        if (sel < 40) begin
            c = wr_cmds[$urandom_range(0, 10)];
            if (c == DCS_PIXEL_FORMAT && $urandom_range(0, 4) != 0)
                r[7:0] = {r[7], good_fmts[$urandom_range(0, 3)],
                          r[3], good_fmts[$urandom_range(0, 3)]};
            add_write(vc, c, r[23:0]);
        end else if (sel < 55) begin
            // column/page window: command phase, maybe a blocked read, then the end byte
            add_write(vc, $urandom_range(0, 1) ? DCS_SET_COLUMN : DCS_SET_PAGE, r[23:0]);
            if ($urandom_range(0, 3) == 0)
                add_pkt(1'b0, vc, DT_DCS_READ, {r[31:8], rd_cmds[$urandom_range(0, 2)]},
                        16'($urandom()));
            add_write(vc, 8'($urandom()), 24'($urandom()));
        end else if (sel < 72) begin
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : rd_cmds[$urandom_range(0, 2)];
            add_pkt(1'b0, vc, DT_DCS_READ, {r[31:8], c}, 16'($urandom()));
        end else if (sel < 80) begin
            if (r[0]) add_pkt(1'b0, vc, DT_SET_MAX_RET, $urandom(), 16'($urandom()));
            else add_pkt(1'b1, vc, DT_NULL, $urandom(), 16'($urandom()));
        end else if (sel < 88) begin
            add_write(vc, 8'($urandom()), r[23:0]);
        end else begin
            add_pkt(r[0], r[2:1], r[8:3], $urandom(), 16'($urandom()));
        end
    endtask

    task automatic write_channel(input logic [1:0] ch);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ch;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        own_ch = ch;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (packet_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    logic [1:0] phase_ch[6] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    int         start_cnt;

    initial begin
        dcs = '0;
        dcs.pwr = POWER_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            write_channel(phase_ch[ph]);
            if (ph == 0) begin
                add_pkt(1'b0, own_ch, DT_DCS_READ, {24'hffffff, DCS_GET_POWER}, 16'hffff);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, {24'hffffff, DCS_SLEEP_OUT}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_READ, {24'h0, DCS_GET_DIAG}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, {24'h0, DCS_SLEEP_OUT}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR1, {24'h0, DCS_DISPLAY_ON}, 16'h0);
                add_pkt(1'b1, own_ch, DT_DCS_LONG_WR, {24'hffffff, DCS_DISPLAY_OFF}, 16'h1);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, {24'h0, DCS_SLEEP_IN}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR1, {24'hffffff, DCS_ADDR_MODE}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_READ, {24'h0, DCS_GET_ADDR}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR1, {16'h0, 8'h01, DCS_TEAR_ON}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR1, {16'h0, 8'h00, DCS_TEAR_ON}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, {24'h0, DCS_TEAR_OFF}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, {24'h0, DCS_TEAR_OFF}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR1, {16'h0, 8'h77, DCS_PIXEL_FORMAT}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR1, {16'h0, 8'h13, DCS_PIXEL_FORMAT}, 16'h0);
                // window commands, a read blocked by the open second phase, then both end bytes
                add_pkt(1'b1, own_ch, DT_DCS_LONG_WR, {24'h341200, DCS_SET_COLUMN}, 16'h4);
                add_pkt(1'b0, own_ch, DT_DCS_READ, {24'h0, DCS_GET_POWER}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, 32'h0000_00ab, 16'h0);
                add_pkt(1'b1, own_ch, DT_DCS_LONG_WR, {24'hff5678, DCS_SET_PAGE}, 16'h3);
                add_pkt(1'b1, own_ch, DT_DCS_LONG_WR, 32'hffffffff, 16'h0);
                add_pkt(1'b0, own_ch, DT_SET_MAX_RET, 32'hffffffff, 16'hffff);
                add_pkt(1'b1, own_ch, DT_NULL, 32'hffffffff, 16'hffff);
                add_pkt(1'b0, own_ch, 6'h3f, 32'h0, 16'h0);
                add_pkt(1'b1, own_ch, DT_DCS_SHORT_WR0, 32'h0, 16'h0);
                add_pkt(1'b0, own_ch + 2'd1, DT_DCS_READ, {24'h0, DCS_GET_POWER}, 16'h0);
                add_pkt(1'b0, own_ch, DT_DCS_SHORT_WR0, 32'h0000_00b0, 16'h0);
                add_pkt(1'b1, own_ch, DT_DCS_LONG_WR, 32'hffffffff, 16'hffff);
            end
            start_cnt = n_items;
            while (n_items - start_cnt < 125) add_random(own_ch);
            wait_drained();
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
